FILE: rtl/core/tcie_pkg.sv
// Package for the toy instruction executor: opcodes, status codes, sizes.
// Used by tcie_mem and toy_cpu_instruction_executor.
`default_nettype none
package tcie_pkg;
   localparam int MEM_WORDS_DEFAULT = 4096;
   localparam int REG_COUNT_DEFAULT = 8;
   localparam int WORD_W = 16;
   localparam int OUT_REGS = 8;

   localparam logic [15:0] OP_NOP  = 16'h00;
   localparam logic [15:0] OP_MOV  = 16'h01;
   localparam logic [15:0] OP_MOVI = 16'h02;
   localparam logic [15:0] OP_LD   = 16'h03;
   localparam logic [15:0] OP_ST   = 16'h04;
   localparam logic [15:0] OP_ADD  = 16'h10;
   localparam logic [15:0] OP_SUB  = 16'h11;
   localparam logic [15:0] OP_INC  = 16'h12;
   localparam logic [15:0] OP_DEC  = 16'h13;
   localparam logic [15:0] OP_AND  = 16'h20;
   localparam logic [15:0] OP_OR   = 16'h21;
   localparam logic [15:0] OP_XOR  = 16'h22;
   localparam logic [15:0] OP_NOT  = 16'h23;
   localparam logic [15:0] OP_JMP  = 16'h40;
   localparam logic [15:0] OP_JZ   = 16'h41;
   localparam logic [15:0] OP_JNZ  = 16'h42;
   localparam logic [15:0] OP_CALL = 16'h43;
   localparam logic [15:0] OP_RET  = 16'h44;
   localparam logic [15:0] OP_IO0  = 16'h60;
   localparam logic [15:0] OP_IO1  = 16'h61;
   localparam logic [15:0] OP_HLT  = 16'hFF;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_OP  = 2'd1;
   localparam logic [1:0] ST_BAD_REG = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE, PH_W0, PH_W1, PH_W2, PH_EXEC
   } phase_type;

   // One memory access from the sequencer.
   typedef struct packed {
      logic        wr;
      logic [15:0] addr;
      logic [15:0] wdata;
   } mem_req_type;
endpackage
`default_nettype wire

FILE: rtl/core/tcie_mem.sv
// Single-port word memory with registered read and a clearing pass.
// Depends on tcie_pkg.
`default_nettype none
module tcie_mem
   import tcie_pkg::*;
#(
   parameter int MEMORY_WORDS = MEM_WORDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire mem_req_type req,
   output logic             clr_busy,
   output logic [15:0]      rdata
);
   localparam int AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
   localparam bit POW2 = ((MEMORY_WORDS & (MEMORY_WORDS - 1)) == 0);
   localparam logic [32:0] RECIP =
      33'(((64'd1 << 32) + 64'(MEMORY_WORDS) - 64'd1) / 64'(MEMORY_WORDS));
   localparam logic [16:0] DEPTH = 17'(MEMORY_WORDS);

   logic [15:0] store [MEMORY_WORDS];
   logic [AW:0] clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0] idx;

   // Address wraps at 16 bits and then modulo the depth. A power-of-two depth
   // is a plain mask; any other depth uses a reciprocal multiplication, which
   // gives the exact quotient for every 16-bit address.
   always_comb begin
      logic [48:0] prod;
      logic [15:0] quo;
      logic [32:0] back;
      logic [15:0] rem;
      prod = 49'(req.addr) * 49'(RECIP);
      quo = prod[47:32];
      back = 33'(quo) * 33'(DEPTH);
      rem = req.addr - back[15:0];
      idx = POW2 ? req.addr[AW-1:0] : rem[AW-1:0];
   end

   assign clr_busy = (clr_cnt_ff < (AW+1)'(MEMORY_WORDS));
   assign clr_cnt_in = clr_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Clearing pass has priority; otherwise one access a cycle.
   always_ff @(posedge clock) begin
      if (clr_busy && !reset) begin
         store[clr_cnt_ff[AW-1:0]] <= '0;
      end else if (en && req.wr) begin
         store[idx] <= req.wdata;
      end
      rdata <= store[idx];
   end
endmodule
`default_nettype wire

FILE: rtl/core/toy_cpu_instruction_executor.sv
// Top level of the toy instruction executor: sequencer, registers, output stage.
// Depends on tcie_pkg and tcie_mem.
// Each request uses the single memory port for three instruction-word writes and one
// load/store slot. The next request is accepted in the execute cycle of the previous
// one. The response is registered through pend_ff and then out_v_ff after execute; a
// waiting response holds execute. A load blocks acceptance from idle for the cycle it
// lands. Reset is synchronous; a clearing pass over all MEMORY_WORDS words follows
// reset, during which no request is accepted.
`default_nettype none
module toy_cpu_instruction_executor
   import tcie_pkg::*;
#(
   parameter int MEMORY_WORDS   = MEM_WORDS_DEFAULT,
   parameter int REGISTER_COUNT = REG_COUNT_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,      // zero_condition
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,      // opcode, operand_a, operand_b
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [151:0]      rsp_tdata      // status, halted, program_counter,
                                            // reg_zero..reg_seven, 5 zero bits
);
   logic        zc_ff;
   phase_type   ph_ff, ph_in;
   logic [15:0] op_ff, a_ff, b_ff;
   logic [15:0] pc_ff, ret_ff;
   logic        halt_ff;
   logic [15:0] rf_ff [16];
   logic        clr_busy;
   logic [15:0] rdata;
   mem_req_type mreq;
   logic        mem_en;
   logic        ld_pend_ff;
   logic [3:0]  ld_reg_ff;
   logic        out_v_ff;
   logic [146:0] out_d_ff;
   logic        can_out;

   logic [3:0] hi_a, lo_a, lo_b;
   assign hi_a = a_ff[7:4];
   assign lo_a = a_ff[3:0];
   assign lo_b = b_ff[3:0];

   // Config register.
   always_ff @(posedge clock) begin
      if (reset) zc_ff <= 1'b0;
      else if (csr_we) zc_ff <= csr_wdata;
   end

   // Register read; a load lands long before the next execute reads it.
   function automatic logic [15:0] rd(input logic [3:0] i);
      return rf_ff[i];
   endfunction

   assign can_out = !out_v_ff || rsp_tready;
   assign req_tready = (ph_ff == PH_IDLE || (ph_ff == PH_EXEC && can_out))
                       && !clr_busy && !ld_pend_ff;
   logic acc;
   assign acc = req_tvalid && req_tready;

   // Sequencer and memory port.
   always_comb begin
      ph_in = ph_ff;
      mreq = '{wr: 1'b0, addr: pc_ff, wdata: req_tdata[15:0]};
      mem_en = 1'b0;
      unique case (ph_ff)
         PH_IDLE: begin
            if (acc) begin ph_in = PH_W1; mem_en = 1'b1; mreq.wr = 1'b1; end
         end
         PH_W0: begin
            ph_in = PH_W1; mem_en = 1'b1; mreq.wr = 1'b1; mreq.wdata = op_ff;
         end
         PH_W1: begin
            ph_in = PH_W2; mem_en = 1'b1; mreq.wr = 1'b1;
            mreq.addr = pc_ff + 16'd1; mreq.wdata = a_ff;
         end
         PH_W2: begin
            ph_in = PH_EXEC; mem_en = 1'b1; mreq.wr = 1'b1;
            mreq.addr = pc_ff + 16'd2; mreq.wdata = b_ff;
         end
         PH_EXEC: begin
            if (can_out) begin
               mem_en = 1'b1;
               if (op_ff == OP_ST) begin
                  mreq.wr = (32'(lo_b) < REGISTER_COUNT);
                  mreq.addr = a_ff; mreq.wdata = rd(lo_b);
               end else begin
                  mreq.addr = b_ff;
               end
               ph_in = acc ? PH_W0 : PH_IDLE;
            end
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) ph_ff <= PH_IDLE;
      else ph_ff <= ph_in;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         op_ff <= req_tdata[15:0];
         a_ff  <= req_tdata[31:16];
         b_ff  <= req_tdata[47:32];
      end
   end

   tcie_mem #(.MEMORY_WORDS(MEMORY_WORDS)) u_mem (
      .clock(clock), .reset(reset), .en(mem_en), .req(mreq),
      .clr_busy(clr_busy), .rdata(rdata)
   );

   // Execute.
   logic exec;
   assign exec = (ph_ff == PH_EXEC) && can_out;
   logic [1:0]  st;
   logic [15:0] pc_n, ret_n, wv;
   logic [3:0]  wi;
   logic        we, ld, halt_n;
   always_comb begin
      logic ok_ha, ok_la, ok_lb;
      ok_ha = 32'(hi_a) < REGISTER_COUNT;
      ok_la = 32'(lo_a) < REGISTER_COUNT;
      ok_lb = 32'(lo_b) < REGISTER_COUNT;
      st = ST_OK; pc_n = pc_ff; ret_n = ret_ff; halt_n = halt_ff;
      we = 1'b0; ld = 1'b0; wi = lo_a; wv = '0;
      unique case (op_ff)
         OP_NOP, OP_IO0, OP_IO1: ;
         OP_MOV: if (ok_ha && ok_la) begin we = 1'b1; wv = rd(hi_a); end
                 else st = ST_BAD_REG;
         OP_MOVI: if (ok_la) begin we = 1'b1; wv = b_ff; end else st = ST_BAD_REG;
         OP_LD: if (ok_la) ld = 1'b1; else st = ST_BAD_REG;
         OP_ST: if (!ok_lb) st = ST_BAD_REG;
         OP_ADD: if (ok_ha && ok_la) begin
                    we = 1'b1; wi = hi_a; wv = rd(hi_a) + rd(lo_a);
                 end else st = ST_BAD_REG;
         OP_SUB, OP_AND, OP_OR, OP_XOR: if (ok_la && ok_lb) begin
                    we = 1'b1;
                    unique case (op_ff)
                       OP_SUB: wv = rd(lo_a) - rd(lo_b);
                       OP_AND: wv = rd(lo_a) & rd(lo_b);
                       OP_OR:  wv = rd(lo_a) | rd(lo_b);
                       default: wv = rd(lo_a) ^ rd(lo_b);
                    endcase
                 end else st = ST_BAD_REG;
         OP_INC, OP_DEC, OP_NOT: if (ok_la) begin
                    we = 1'b1;
                    unique case (op_ff)
                       OP_INC: wv = rd(lo_a) + 16'd1;
                       OP_DEC: wv = rd(lo_a) - 16'd1;
                       default: wv = ~rd(lo_a);
                    endcase
                 end else st = ST_BAD_REG;
         OP_JMP: pc_n = a_ff;
         OP_JZ: if (zc_ff) pc_n = a_ff;
         OP_JNZ: if (!zc_ff) pc_n = a_ff;
         OP_CALL: begin ret_n = pc_ff; pc_n = a_ff; end
         OP_RET: pc_n = ret_ff;
         OP_HLT: halt_n = 1'b1;
         default: st = ST_BAD_OP;
      endcase
   end

   // State update; load data lands in the cycle after execute, as does the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0; ret_ff <= '0; halt_ff <= 1'b0; ld_pend_ff <= 1'b0;
         for (int i = 0; i < 16; i++) rf_ff[i] <= '0;
      end else begin
         ld_pend_ff <= exec && ld;
         if (exec) begin
            pc_ff <= pc_n; ret_ff <= ret_n; halt_ff <= halt_n;
            if (we) rf_ff[wi] <= wv;
            ld_reg_ff <= lo_a;
         end
         if (ld_pend_ff) rf_ff[ld_reg_ff] <= rdata;
      end
   end

   // Output register: result formed as a load lands, with the landing data forwarded.
   logic [1:0] st_ff;
   logic       pend_ff;
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else pend_ff <= exec;
      if (exec) st_ff <= st;
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (pend_ff) out_v_ff <= 1'b1;
      else if (rsp_tready) out_v_ff <= 1'b0;
   end

   // Only registers 0 to 7 are reported; a landing load is forwarded into them.
   logic [146:0] out_d_ff_in;
   always_comb begin
      logic [127:0] regs;
      for (int j = 0; j < OUT_REGS; j++)
         regs[j*16 +: 16] = (j < REGISTER_COUNT) ? rf_ff[j] : 16'd0;
      if (ld_pend_ff && !ld_reg_ff[3]) regs[ld_reg_ff[2:0]*16 +: 16] = rdata;
      out_d_ff_in = {regs, pc_ff, halt_ff, st_ff};
   end
   always_ff @(posedge clock) begin
      if (pend_ff) out_d_ff <= out_d_ff_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {5'b0, out_d_ff};

   // A result never gets overwritten while waiting.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready |-> !pend_ff) else $error("result overwritten");
   a_noacc_clr: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_tready) else $error("accept during clear");
   a_exec: assert property (@(posedge clock) disable iff (reset)
      exec |=> pend_ff) else $error("lost result");
endmodule
`default_nettype wire

FILE: verif/tb_toy_cpu_instruction_executor.sv
// Testbench for the toy instruction executor: directed and random instruction requests.
// A scoreboard class models registers, memory, pc and flags and checks every response.
// Depends on tcie_pkg and the RTL of toy_cpu_instruction_executor.
`timescale 1ns / 1ps

module tb_toy_cpu_instruction_executor;
   import tcie_pkg::*;

   localparam int MEM_WORDS = 4096;
   localparam int REG_COUNT = 8;
   localparam int RANDOM_ITEMS = 900;
   localparam int QUIET_TAIL = 150;
   localparam longint CYCLE_LIMIT = 2000000;

   // Architectural model of the executor; holds expected responses in order.
   class exec_scoreboard;
      logic [15:0] regs [16];
      logic [15:0] mem [MEM_WORDS];
      logic [15:0] pc;
      logic [15:0] ret_addr;
      logic        halt;
      logic        zero_cond;
      logic [151:0] pending [$];
      int          mismatches;

      function new();
         for (int i = 0; i < 16; i++) regs[i] = '0;
         for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
         pc = '0;
         ret_addr = '0;
         halt = 1'b0;
         zero_cond = 1'b0;
         mismatches = 0;
      endfunction

      // Apply one accepted instruction and queue the state it leaves behind.
      function void note_request(logic [15:0] op, logic [15:0] a, logic [15:0] b);
         logic [3:0]   ha, la, lb;
         logic [1:0]   st;
         logic [151:0] rsp;
         ha = a[7:4];
         la = a[3:0];
         lb = b[3:0];
         st = ST_OK;
         mem[pc % MEM_WORDS] = op;
         mem[(16'(pc + 16'd1)) % MEM_WORDS] = a;
         mem[(16'(pc + 16'd2)) % MEM_WORDS] = b;
         case (op)
            OP_NOP, OP_IO0, OP_IO1: ;
            OP_MOV: if (ha < REG_COUNT && la < REG_COUNT) regs[la] = regs[ha];
                    else st = ST_BAD_REG;
            OP_MOVI: if (la < REG_COUNT) regs[la] = b; else st = ST_BAD_REG;
            OP_LD: if (la < REG_COUNT) regs[la] = mem[b % MEM_WORDS]; else st = ST_BAD_REG;
            OP_ST: if (lb < REG_COUNT) mem[a % MEM_WORDS] = regs[lb]; else st = ST_BAD_REG;
            OP_ADD: if (ha < REG_COUNT && la < REG_COUNT) regs[ha] = regs[ha] + regs[la];
                    else st = ST_BAD_REG;
            OP_SUB, OP_AND, OP_OR, OP_XOR: begin
               if (la < REG_COUNT && lb < REG_COUNT) begin
                  case (op)
                     OP_SUB: regs[la] = regs[la] - regs[lb];
                     OP_AND: regs[la] = regs[la] & regs[lb];
                     OP_OR:  regs[la] = regs[la] | regs[lb];
                     default: regs[la] = regs[la] ^ regs[lb];
                  endcase
               end else st = ST_BAD_REG;
            end
            OP_INC, OP_DEC, OP_NOT: begin
               if (la < REG_COUNT) begin
                  case (op)
                     OP_INC: regs[la] = regs[la] + 16'd1;
                     OP_DEC: regs[la] = regs[la] - 16'd1;
                     default: regs[la] = ~regs[la];
                  endcase
               end else st = ST_BAD_REG;
            end
            OP_JMP: pc = a;
            OP_JZ: if (zero_cond) pc = a;
            OP_JNZ: if (!zero_cond) pc = a;
            OP_CALL: begin
               ret_addr = pc;
               pc = a;
            end
            OP_RET: pc = ret_addr;
            OP_HLT: halt = 1'b1;
            default: st = ST_BAD_OP;
         endcase
         rsp = '0;
         rsp[1:0] = st;
         rsp[2] = halt;
         rsp[18:3] = pc;
         for (int j = 0; j < 8; j++) rsp[19 + 16*j +: 16] = (j < REG_COUNT) ? regs[j] : '0;
         pending = {pending, rsp};
      endfunction

      // Compare one response with the oldest expectation, field by field.
      function void check_response(logic [151:0] got);
         logic [151:0] want;
         bit bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending.pop_front();
         bad = (got[1:0] !== want[1:0]) || (got[2] !== want[2]) || (got[18:3] !== want[18:3]);
         for (int j = 0; j < 8; j++)
            if (got[19 + 16*j +: 16] !== want[19 + 16*j +: 16]) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"response mismatch: expected st=%0d h=%0b pc=%h regs=%h, ",
                         "got st=%0d h=%0b pc=%h regs=%h"},
                        want[1:0], want[2], want[18:3], want[146:19],
                        got[1:0], got[2], got[18:3], got[146:19]);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic         csr_wdata = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;   // opcode, operand_a, operand_b
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;        // status, halted, program_counter, reg_zero..reg_seven

   exec_scoreboard sb = new();
   bit  quiet = 1'b0;
   bit  stim_done = 1'b0;
   longint cycles = 0;

   always #5 clock = ~clock;

   toy_cpu_instruction_executor u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Cycle watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Response side: random stall bursts, checking on every accepted response.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            repeat (gap - 1) begin
               @(posedge clock);
            end
         end else rsp_tready <= 1'b1;
      end
   end

   // Present one instruction and hold it until it is accepted. The valid stays
   // high after acceptance so that the next request can follow with no gap.
   task automatic send_request(logic [15:0] op, logic [15:0] a, logic [15:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, a, b);
   endtask

   // Wait for all responses, let the pipeline settle, then change the zero flag.
   task automatic write_zero_flag(logic v);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.zero_cond = v;
   endtask

   function automatic logic [15:0] pick_opcode();
      logic [15:0] ops [21] = '{OP_NOP, OP_MOV, OP_MOVI, OP_LD, OP_ST, OP_ADD, OP_SUB,
         OP_INC, OP_DEC, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_JMP, OP_JZ, OP_JNZ, OP_CALL,
         OP_RET, OP_IO0, OP_IO1, OP_HLT};
      if ($urandom_range(0, 19) == 0) return 16'($urandom());
      return ops[$urandom_range(0, 20)];
   endfunction

   // Operands mostly hit valid registers, sometimes invalid ones, sometimes anything.
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 3))
         0: return 16'($urandom());
         1: return {8'($urandom()), 1'b0, 3'($urandom()), 1'b0, 3'($urandom())};
         2: return {4'($urandom()), 12'($urandom_range(0, 63))};
         default: return {12'($urandom()), 4'($urandom())};
      endcase
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, every opcode but NOP, invalid register and unknown opcode.
      send_request(OP_MOVI, 16'h0000, 16'hFFFF);
      send_request(OP_MOVI, 16'h0007, 16'h8001);
      send_request(OP_ADD, 16'h0007, 16'h0000);
      send_request(OP_MOV, 16'h0071, 16'h0000);
      send_request(OP_SUB, 16'h0002, 16'h0001);
      send_request(OP_INC, 16'h0000, 16'h0000);
      send_request(OP_DEC, 16'h0003, 16'h0000);
      send_request(OP_AND, 16'h0003, 16'h0007);
      send_request(OP_OR, 16'h0004, 16'h0007);
      send_request(OP_XOR, 16'h0004, 16'h0003);
      send_request(OP_NOT, 16'h0005, 16'h0000);
      send_request(OP_ST, 16'hFFFF, 16'h0007);
      send_request(OP_LD, 16'h0006, 16'h0FFF);
      send_request(OP_LD, 16'h0005, 16'hF001);
      send_request(OP_MOVI, 16'h000F, 16'h1234);
      send_request(OP_ADD, 16'h0081, 16'h0000);
      send_request(OP_ST, 16'h0010, 16'hFFF8);
      send_request(OP_JZ, 16'h1234, 16'h0000);
      send_request(OP_JNZ, 16'hFFFE, 16'h0000);
      send_request(OP_IO0, 16'h0000, 16'h0000);
      send_request(OP_IO1, 16'hFFFF, 16'hFFFF);
      send_request(OP_CALL, 16'h0100, 16'h0000);
      send_request(OP_RET, 16'h0000, 16'h0000);
      send_request(16'hFFFE, 16'h0000, 16'h0000);
      write_zero_flag(1'b1);
      send_request(OP_JZ, 16'h4321, 16'h0000);
      send_request(OP_JMP, 16'hFFFF, 16'h0000);
      send_request(OP_ADD, 16'h0000, 16'h0000);
      send_request(OP_HLT, 16'h0000, 16'h0000);
      // Random phase, changing the zero flag between segments.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 149) write_zero_flag(1'($urandom()));
         if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
         send_request(pick_opcode(), pick_operand(), pick_operand());
      end
      write_zero_flag(1'b0);
      send_request(OP_JNZ, 16'h0042, 16'h0000);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/tcie_pkg.sv
rtl/core/tcie_mem.sv
rtl/core/toy_cpu_instruction_executor.sv
verif/tb_toy_cpu_instruction_executor.sv
